[rtl/uud_pkg.sv]
`default_nettype none
package uud_pkg;

  localparam int JQ_DEPTH = 4;
  localparam int JQ_AW = $clog2(JQ_DEPTH);

  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_CR = 8'h0d;

  // One decoded group waiting for the back end: the packed 24-bit word,
  // how many of its bytes are owed, and whether it is the end marker.
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  cnt;
    logic        endm;
  } job_t;

endpackage
`default_nettype wire

[rtl/uud_front.sv]
`default_nettype none
module uud_front (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [7:0]  in_char,
  output logic             job_push,
  output uud_pkg::job_t    job
);
  import uud_pkg::*;

  localparam logic [1:0] PH_COUNT = 2'd0;
  localparam logic [1:0] PH_DATA  = 2'd1;
  localparam logic [1:0] PH_SKIP  = 2'd2;
  localparam logic [1:0] PH_ENDED = 2'd3;

  logic [1:0]  phase, phase_next;
  logic [5:0]  owed, owed_next;
  logic [1:0]  gpos, gpos_next;
  logic [17:0] acc, acc_next;
  logic [5:0]  sextet;
  logic [1:0]  n;

  assign sextet = in_char[5:0] - 6'h20;
  assign n = (owed < 6'd3) ? owed[1:0] : 2'd3;

  always_comb begin
    phase_next = phase;
    owed_next  = owed;
    gpos_next  = gpos;
    acc_next   = acc;
    job_push   = 1'b0;
    job.word   = {acc, sextet};
    job.cnt    = n;
    job.endm   = 1'b0;
    if (accept && in_char != CH_CR) begin
      unique case (phase)
        PH_COUNT: begin
          if (in_char != CH_LF) begin
            gpos_next = 2'd0;
            acc_next  = 18'd0;
            if (sextet == 6'd0) begin
              phase_next = PH_ENDED;
              owed_next  = 6'd0;
              job_push   = 1'b1;
              job.word   = 24'd0;
              job.cnt    = 2'd1;
              job.endm   = 1'b1;
            end else begin
              phase_next = PH_DATA;
              owed_next  = sextet;
            end
          end
        end
        PH_DATA: begin
          if (in_char == CH_LF) begin
            phase_next = PH_COUNT;
            owed_next  = 6'd0;
            gpos_next  = 2'd0;
            acc_next   = 18'd0;
          end else if (gpos != 2'd3) begin
            acc_next  = {acc[11:0], sextet};
            gpos_next = gpos + 2'd1;
          end else begin
            job_push  = (n != 2'd0);
            owed_next = owed - {4'd0, n};
            gpos_next = 2'd0;
            acc_next  = 18'd0;
            if (owed_next == 6'd0) begin
              phase_next = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          if (in_char == CH_LF) begin
            phase_next = PH_COUNT;
          end
        end
        PH_ENDED: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_COUNT;
      owed  <= 6'd0;
      gpos  <= 2'd0;
      acc   <= 18'd0;
    end else begin
      phase <= phase_next;
      owed  <= owed_next;
      gpos  <= gpos_next;
      acc   <= acc_next;
    end
  end

endmodule
`default_nettype wire

[rtl/uud_jobq.sv]
`default_nettype none
module uud_jobq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr,
  input  wire uud_pkg::job_t wdata,
  input  wire logic          rd,
  output uud_pkg::job_t      rdata,
  output logic               full,
  output logic               nonempty
);
  import uud_pkg::*;

  job_t              slots [JQ_DEPTH];
  logic [JQ_AW-1:0]  wptr;
  logic [JQ_AW-1:0]  rptr;
  logic [JQ_AW:0]    count;

  assign full     = (count == (JQ_AW+1)'(JQ_DEPTH));
  assign nonempty = (count != '0);
  assign rdata    = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + JQ_AW'(1);
      end
      if (rd) begin
        rptr <= rptr + JQ_AW'(1);
      end
      if (wr && !rd) begin
        count <= count + (JQ_AW+1)'(1);
      end else if (rd && !wr) begin
        count <= count - (JQ_AW+1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

[rtl/uud_back.sv]
`default_nettype none
module uud_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          job_ready,
  input  wire uud_pkg::job_t job,
  output logic               job_pop,
  input  wire logic          pop,
  output logic               empty,
  output logic [7:0]         out_byte,
  output logic               last,
  output logic               end_mark
);
  import uud_pkg::*;

  logic       held;
  logic [1:0] idx;
  logic       load;
  logic       done;
  logic [7:0] sel_byte;

  assign empty = !held;
  assign load  = job_ready && (!held || pop);
  assign done  = (idx + 2'd1 == job.cnt);
  assign job_pop = load && done;

  always_comb begin
    case (idx)
      2'd0:    sel_byte = job.word[23:16];
      2'd1:    sel_byte = job.word[15:8];
      default: sel_byte = job.word[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= sel_byte;
      last     <= done;
      end_mark <= job.endm;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      idx  <= 2'd0;
    end else begin
      if (load) begin
        held <= 1'b1;
        idx  <= done ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        held <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/uudecode_stream_decoder.sv]
`default_nettype none
// Decodes the body of a uuencoded text, one character per item, into bytes.
// One character is taken every cycle while full is low; the front end
// decodes it in that cycle, and each completed group of four characters
// (or a zero-count line's end marker) joins a four-entry group queue. The
// back end emits one byte per cycle from that queue into the result
// register while results are taken, so a group's up to three bytes keep
// pace with its four characters. A decoded byte is registered first in
// the group queue and then in the result register.
module uudecode_stream_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_char,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            last,
  output logic            end_mark
);
  import uud_pkg::*;

  logic  accept;
  logic  job_push;
  job_t  job_in;
  job_t  job_out;
  logic  job_pop;
  logic  jq_nonempty;

  assign accept = push && !full;

  uud_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_char  (in_char),
    .job_push (job_push),
    .job      (job_in)
  );

  uud_jobq u_jobq (
    .clk      (clk),
    .rst      (rst),
    .wr       (job_push),
    .wdata    (job_in),
    .rd       (job_pop),
    .rdata    (job_out),
    .full     (full),
    .nonempty (jq_nonempty)
  );

  uud_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_ready (jq_nonempty),
    .job       (job_out),
    .job_pop   (job_pop),
    .pop       (pop),
    .empty     (empty),
    .out_byte  (out_byte),
    .last      (last),
    .end_mark  (end_mark)
  );

endmodule
`default_nettype wire

[rtl/uud_checker.sv]
`default_nettype none
module uud_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] out_byte,
  input wire logic       last,
  input wire logic       end_mark
);

  // After reset no result is waiting.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown straight after reset");

  // The end marker carries a zero byte and closes its item.
  a_end_form: assert property (@(posedge clk) disable iff (rst)
    (!empty && end_mark) |-> (out_byte == 8'd0 && last))
    else $error("malformed end marker");

  // A result not taken stays unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(last)
                          && $stable(end_mark)))
    else $error("waiting result changed");

  // Nothing follows a taken end marker without a new character.
  a_after_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && end_mark && pop) |=> empty)
    else $error("result after end marker");

endmodule

bind uudecode_stream_decoder uud_checker u_chk (.*);
`default_nettype wire

[test/uudecode_stream_decoder_tb.sv]
`default_nettype none
module uudecode_stream_decoder_tb;
  import uud_pkg::*;

  typedef enum logic [1:0] {PH_COUNT, PH_DATA, PH_SKIP, PH_ENDED} line_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       endm;
  } decoded_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic [7:0] in_char = 8'h00;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic       last;
  logic       end_mark;

  line_phase_t phase = PH_COUNT;
  logic [5:0]  owed = 6'd0;
  logic [1:0]  grp_pos = 2'd0;
  logic [17:0] held = 18'd0;

  decoded_t decoded_fifo[$];
  bit       idle_on = 1'b1;
  int       chars_sent = 0;
  int       bytes_seen = 0;
  int       lines_sent = 0;
  int       bad_count = 0;
  int       pop_stall = 0;

  uudecode_stream_decoder u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_char(in_char),
    .empty(empty), .pop(pop), .out_byte(out_byte), .last(last), .end_mark(end_mark)
  );

  always #6 clk = ~clk;

  function automatic logic [5:0] sextet_of(input logic [7:0] c);
    logic [7:0] d;
    d = c - 8'h20;
    return d[5:0];
  endfunction

  // Picks one of the four characters that map to the sextet, never LF or CR.
  function automatic logic [7:0] char_for(input logic [5:0] s);
    logic [7:0] c;
    do begin
      c = 8'(32'h20 + s + 64 * $urandom_range(0, 3));
    end while (c == CH_LF || c == CH_CR);
    return c;
  endfunction

  task automatic decode_char(input logic [7:0] c);
    logic [5:0]  s;
    logic [23:0] word;
    int          n;
    s = sextet_of(c);
    if (c == CH_CR || phase == PH_ENDED) return;
    case (phase)
      PH_COUNT: begin
        if (c != CH_LF) begin
          owed = s;
          grp_pos = 2'd0;
          held = 18'd0;
          if (s == 6'd0) begin
            phase = PH_ENDED;
            decoded_fifo.push_back('{data: 8'h00, last: 1'b1, endm: 1'b1});
          end else begin
            phase = PH_DATA;
          end
        end
      end
      PH_SKIP: begin
        if (c == CH_LF) phase = PH_COUNT;
      end
      default: begin
        if (c == CH_LF) begin
          phase = PH_COUNT;
          owed = 6'd0;
          grp_pos = 2'd0;
          held = 18'd0;
        end else if (grp_pos < 2'd3) begin
          held = {held[11:0], s};
          grp_pos = grp_pos + 2'd1;
        end else begin
          word = {held, s};
          n = (owed < 6'd3) ? int'(owed) : 3;
          for (int i = 0; i < n; i++) begin
            decoded_fifo.push_back('{data: word[23 - 8 * i -: 8], last: (i == n - 1),
                                     endm: 1'b0});
          end
          owed = owed - 6'(n);
          grp_pos = 2'd0;
          held = 18'd0;
          if (owed == 6'd0) phase = PH_SKIP;
        end
      end
    endcase
  endtask

  // A character that would end the data early in the count phase is nudged
  // unless the end of data is wanted.
  task automatic send_char(input logic [7:0] c, input bit may_end = 1'b0);
    if (!may_end && phase == PH_COUNT && c != CH_LF && c != CH_CR &&
        sextet_of(c) == 6'd0) begin
      c = c ^ 8'h01;
    end
    if (idle_on && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    push <= 1'b1;
    in_char <= c;
    do @(posedge clk); while (full);
    decode_char(c);
    chars_sent++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk); while (decoded_fifo.size() != 0);
  endtask

  // kind: 0 well-formed, 1 well-formed with trailing junk, 2 short line.
  task automatic send_line(input int cnt, input int kind);
    int nchars;
    nchars = 4 * ((cnt + 2) / 3);
    if (kind == 2) nchars = $urandom_range(0, nchars - 1);
    send_char(char_for(6'(cnt)));
    for (int i = 0; i < nchars; i++) begin
      if ($urandom_range(0, 15) == 0) send_char(CH_CR);
      send_char(char_for(6'($urandom_range(0, 63))));
    end
    if (kind == 1) begin
      repeat ($urandom_range(1, 4)) send_char(char_for(6'($urandom_range(0, 63))));
    end
    if ($urandom_range(0, 3) == 0) send_char(CH_CR);
    send_char(CH_LF);
    lines_sent++;
  endtask

  task automatic test_directed();
    send_char(CH_LF);
    send_char(CH_CR);
    // One byte owed, all-ones sextets in four spellings.
    send_char(8'h21);
    send_char(8'h5f);
    send_char(8'hdf);
    send_char(8'h1f);
    send_char(8'h9f);
    send_char(8'h78);
    send_char(CH_CR);
    send_char(CH_LF);
    // Three bytes of zero, then straight to the next line.
    send_char(8'h23);
    send_char(8'h20);
    send_char(8'h60);
    send_char(8'ha0);
    send_char(8'he0);
    send_char(CH_LF);
    // Five owed, a CR inside the group, then cut short after a partial group.
    send_char(8'h25);
    send_char(8'h00);
    send_char(CH_CR);
    send_char(8'hff);
    send_char(8'h80);
    send_char(8'h7f);
    send_char(8'h41);
    send_char(8'hc2);
    send_char(CH_LF);
    lines_sent += 4;
  endtask

  task automatic test_random_lines(input int target);
    int first;
    int r;
    int cnt;
    first = chars_sent;
    while (chars_sent - first < target) begin
      r = $urandom_range(0, 99);
      cnt = $urandom_range(0, 99) < 70 ? $urandom_range(1, 12) :
            $urandom_range(0, 99) < 85 ? $urandom_range(13, 45) :
            $urandom_range(0, 1) ? 63 : $urandom_range(46, 63);
      if (r < 55) begin
        send_line(cnt, 0);
      end else if (r < 70) begin
        send_line(cnt, 1);
      end else if (r < 82) begin
        send_line(cnt, 2);
      end else if (r < 90) begin
        if ($urandom_range(0, 1)) send_char(CH_CR);
        send_char(CH_LF);
      end else begin
        repeat ($urandom_range(1, 10)) send_char(8'($urandom_range(0, 255)));
        send_char(CH_LF);
      end
    end
  endtask

  task automatic test_pause_until_drained();
    send_line($urandom_range(6, 12), 0);
    send_line($urandom_range(1, 12), 1);
    wait_drained();
    send_line($urandom_range(1, 12), 0);
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    test_random_lines(40);
  endtask

  task automatic test_end_of_data();
    send_char(CH_LF);
    send_char(char_for(6'd0), 1'b1);
    repeat (16) send_char(8'($urandom_range(0, 255)), 1'b1);
    send_char(8'h21, 1'b1);
    send_char(8'hde, 1'b1);
  endtask

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (decoded_fifo.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("Unexpected result: byte %02h last %0b end %0b", out_byte, last, end_mark);
      end else begin
        decoded_t want;
        want = decoded_fifo.pop_front();
        bytes_seen++;
        if (want.data !== out_byte || want.last !== last || want.endm !== end_mark) begin
          bad_count++;
          if (bad_count <= 10)
            $display("Mismatch on result %0d: expected byte %02h last %0b end %0b, got %02h %0b %0b",
                     bytes_seen, want.data, want.last, want.endm, out_byte, last, end_mark);
        end
      end
    end
    if (pop_stall > 0) begin
      pop_stall--;
      pop <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      pop_stall = $urandom_range(0, 7);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_lines(140);
    test_pause_until_drained();
    test_random_lines(140);
    test_steady_stream();
    test_end_of_data();
    wait_drained();
    repeat (16) @(posedge clk);
    $display("Sent %0d characters over %0d lines; checked %0d results up to the end marker.",
             chars_sent, lines_sent, bytes_seen);
    $display("Blank, short and junk-tailed lines, CRs, noise and a drained pause were covered.");
    if (bad_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d failures in total.", bad_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Timed out with %0d results still awaited.", decoded_fifo.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire
